>>> hw/rtl/drive_axis_start_stop_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the axis start/stop sequencer
// Checks written against the sequencer's clock and synchronous reset.
// ----------------------------------------------------------------------------
`ifndef DRIVE_AXIS_START_STOP_SEQUENCER_MACROS_SVH
`define DRIVE_AXIS_START_STOP_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define DASS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define DASS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dass_pkg.sv
// ----------------------------------------------------------------------------
// dass_pkg
// Types and constants shared by the axis start/stop sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dass_pkg;

  // Sequencer phases, encoded as reported on axis_state.
  typedef enum logic [2:0] {
    PH_OFF    = 3'd0,
    PH_START1 = 3'd1,
    PH_START2 = 3'd2,
    PH_START3 = 3'd3,
    PH_STOP1  = 3'd4,
    PH_STOP2  = 3'd5,
    PH_TRACK  = 3'd6
  } phase_t;

  // Trajectory action codes.
  typedef enum logic [1:0] {
    TRAJ_NONE = 2'd0,
    TRAJ_SEND = 2'd1,
    TRAJ_HOLD = 2'd2
  } traj_t;

  // Alarm codes.
  typedef enum logic [2:0] {
    ALM_NONE        = 3'd0,
    ALM_STANDBY_ERR = 3'd1,
    ALM_ENCODER_ERR = 3'd2,
    ALM_DRIVE_DROP  = 3'd3,
    ALM_TIMEOUT     = 3'd4
  } alarm_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CODE_SHUTDOWN = 3'd0,
    REG_CODE_STANDBY  = 3'd1,
    REG_CODE_ENCODER  = 3'd2,
    REG_STANDBY_WAIT  = 3'd3,
    REG_ENCODER_WAIT  = 3'd4,
    REG_SHUTDOWN_WAIT = 3'd5,
    REG_STOP_WAIT     = 3'd6,
    REG_TRACK_TIMEOUT = 3'd7
  } cfg_reg_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 27;
  localparam int unsigned WaitWidth     = 11;

  // Register reset values.
  localparam logic [3:0]  RST_CODE_SHUTDOWN = 4'd0;
  localparam logic [3:0]  RST_CODE_STANDBY  = 4'd1;
  localparam logic [3:0]  RST_CODE_ENCODER  = 4'd2;
  localparam logic [9:0]  RST_STANDBY_WAIT  = 10'd100;
  localparam logic [9:0]  RST_ENCODER_WAIT  = 10'd100;
  localparam logic [9:0]  RST_SHUTDOWN_WAIT = 10'd100;
  localparam logic [9:0]  RST_STOP_WAIT     = 10'd200;
  localparam logic [26:0] RST_TRACK_TIMEOUT = 27'd3000;

  // Day wrap of the command age, in ms.
  localparam logic signed [28:0] WRAP_LIMIT_MS = -29'sd3600000;
  localparam logic signed [28:0] DAY_MS        = 29'sd86400000;

  // One input word.
  typedef struct packed {
    logic [3:0]         drive_mode;
    logic               track_request;
    logic signed [27:0] track_age_ms;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [2:0] axis_state;
    logic       mode_cmd_valid;
    logic [3:0] mode_cmd;
    logic [1:0] traj_action;
    logic [2:0] alarm;
  } out_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/drive_axis_start_stop_sequencer.sv
// ----------------------------------------------------------------------------
// drive_axis_start_stop_sequencer
// Start/stop sequencer for one telescope axis drive, one word per tick.
// ----------------------------------------------------------------------------
// Each accepted input word is one heartbeat tick. It is captured in an input
// register, run through the sequencer's next-state logic when the result
// register is free or being emptied, and its result word is held in the
// output register until taken. The block accepts one word per clock cycle
// while the result register is not held by out_stall. The per-tick state
// update (phase, wait counter, retry flag, last request) is combinational
// from the input register, which lets a word be processed in every cycle
// that out_stall does not hold. Configuration registers must be written
// through the cfg_ port only while no word is in flight; the block itself
// does not enforce this.
`default_nettype none

`include "drive_axis_start_stop_sequencer_macros.svh"

module drive_axis_start_stop_sequencer
  import dass_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Configuration write port
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_wdata,
  // Input channel
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire in_word_t                 in_data,
  // Result channel
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      out_word_t                out_data
);

  // Configuration registers.
  logic [3:0]  code_shutdown_r, code_standby_r, code_encoder_r;
  logic [9:0]  standby_wait_r, encoder_wait_r, shutdown_wait_r, stop_wait_r;
  logic [26:0] track_timeout_r;

  // Pipeline registers.
  logic      in_valid_r;
  in_word_t  in_data_r;
  logic      out_valid_r;
  out_word_t out_data_r;

  // Sequencer state.
  phase_t               phase_r, phase_nxt;
  logic [WaitWidth-1:0] wait_r, wait_nxt;
  logic                 retry_r, retry_nxt;
  logic                 last_req_r, last_req_nxt;
  out_word_t            result_nxt;

  logic proc;
  logic in_take;

  // A word is processed when the result register is free or being emptied.
  assign proc     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_shutdown_r <= RST_CODE_SHUTDOWN;
      code_standby_r  <= RST_CODE_STANDBY;
      code_encoder_r  <= RST_CODE_ENCODER;
      standby_wait_r  <= RST_STANDBY_WAIT;
      encoder_wait_r  <= RST_ENCODER_WAIT;
      shutdown_wait_r <= RST_SHUTDOWN_WAIT;
      stop_wait_r     <= RST_STOP_WAIT;
      track_timeout_r <= RST_TRACK_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CODE_SHUTDOWN: code_shutdown_r <= cfg_wdata[3:0];
        REG_CODE_STANDBY:  code_standby_r  <= cfg_wdata[3:0];
        REG_CODE_ENCODER:  code_encoder_r  <= cfg_wdata[3:0];
        REG_STANDBY_WAIT:  standby_wait_r  <= cfg_wdata[9:0];
        REG_ENCODER_WAIT:  encoder_wait_r  <= cfg_wdata[9:0];
        REG_SHUTDOWN_WAIT: shutdown_wait_r <= cfg_wdata[9:0];
        REG_STOP_WAIT:     stop_wait_r     <= cfg_wdata[9:0];
        REG_TRACK_TIMEOUT: track_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Command age: sign extend, apply the day wrap and take the magnitude.
  logic signed [28:0] age_ext, age_wrap;
  logic [27:0]        age_mag;
  logic               timed_out;

  always_comb begin
    age_ext  = {in_data_r.track_age_ms[27], in_data_r.track_age_ms};
    age_wrap = (age_ext < WRAP_LIMIT_MS) ? 29'(age_ext + DAY_MS) : age_ext;
    age_mag  = age_wrap[28] ? 28'(-age_wrap) : age_wrap[27:0];
    timed_out = age_mag > {1'b0, track_timeout_r};
  end

  // Wait counter countdown: expires at zero or one and then rests at zero.
  logic                 wait_expired;
  logic [WaitWidth-1:0] wait_dec;

  // Next state and result for the word in the input register.
  always_comb begin
    logic [3:0] drive;
    logic       req;
    logic       cmd_valid;
    logic [3:0] cmd;
    traj_t      traj;
    alarm_t     alarm;

    drive     = in_data_r.drive_mode;
    req       = in_data_r.track_request;
    cmd_valid = 1'b0;
    cmd       = 4'd0;
    traj      = TRAJ_NONE;
    alarm     = ALM_NONE;

    phase_nxt    = phase_r;
    wait_nxt     = wait_r;
    retry_nxt    = retry_r;
    last_req_nxt = last_req_r;

    // A change of request starts an idle axis or stops an active one.
    if (req != last_req_r) begin
      if (!req && phase_r != PH_OFF) begin
        phase_nxt = PH_STOP1;
      end else if (req && phase_r == PH_OFF) begin
        retry_nxt = 1'b0;
        wait_nxt  = '0;
        phase_nxt = PH_START1;
      end
      last_req_nxt = req;
    end

    // A stale track command stops an axis that is starting or tracking.
    if (timed_out && phase_nxt != PH_OFF && phase_nxt != PH_STOP1 &&
        phase_nxt != PH_STOP2) begin
      phase_nxt = PH_STOP1;
      alarm     = ALM_TIMEOUT;
    end

    wait_expired = wait_nxt <= WaitWidth'(1);
    wait_dec     = wait_expired ? '0 : WaitWidth'(wait_nxt - WaitWidth'(1));

    unique case (phase_nxt)
      PH_START1: begin
        if (drive == code_shutdown_r) begin
          cmd_valid = 1'b1;
          cmd       = code_standby_r;
          wait_nxt  = {1'b0, standby_wait_r};
          phase_nxt = PH_START2;
        end else if (wait_nxt != '0) begin
          wait_nxt = WaitWidth'(wait_nxt - WaitWidth'(1));
        end else begin
          wait_nxt  = {1'b0, standby_wait_r};
          phase_nxt = PH_START2;
        end
      end
      PH_START2: begin
        if (drive == code_standby_r) begin
          cmd_valid = 1'b1;
          cmd       = code_encoder_r;
          retry_nxt = 1'b0;
          wait_nxt  = {1'b0, encoder_wait_r};
          phase_nxt = PH_START3;
        end else if (wait_expired) begin
          wait_nxt  = '0;
          cmd_valid = 1'b1;
          cmd       = code_shutdown_r;
          if (!retry_nxt) begin
            retry_nxt = 1'b1;
            phase_nxt = PH_START1;
            wait_nxt  = {1'b0, shutdown_wait_r};
          end else begin
            phase_nxt = PH_OFF;
            alarm     = ALM_STANDBY_ERR;
          end
        end else begin
          wait_nxt = wait_dec;
        end
      end
      PH_START3: begin
        if (drive == code_encoder_r) begin
          phase_nxt = PH_TRACK;
        end else if (wait_expired) begin
          wait_nxt  = '0;
          cmd_valid = 1'b1;
          if (!retry_nxt) begin
            retry_nxt = 1'b1;
            cmd       = code_standby_r;
            phase_nxt = PH_START2;
            wait_nxt  = {standby_wait_r, 1'b0};
          end else begin
            cmd       = code_shutdown_r;
            phase_nxt = PH_OFF;
            alarm     = ALM_ENCODER_ERR;
          end
        end else begin
          wait_nxt = wait_dec;
        end
      end
      PH_STOP1: begin
        wait_nxt  = {1'b0, stop_wait_r};
        traj      = TRAJ_HOLD;
        phase_nxt = PH_STOP2;
      end
      PH_STOP2: begin
        wait_nxt = wait_dec;
        if (wait_expired) begin
          cmd_valid = 1'b1;
          cmd       = code_standby_r;
          phase_nxt = PH_OFF;
        end
      end
      PH_TRACK: begin
        if (drive != code_encoder_r) begin
          phase_nxt = PH_STOP1;
          alarm     = ALM_DRIVE_DROP;
        end else begin
          traj = TRAJ_SEND;
        end
      end
      PH_OFF: ;
      default: phase_nxt = PH_OFF;
    endcase

    result_nxt.axis_state     = phase_nxt;
    result_nxt.mode_cmd_valid = cmd_valid;
    result_nxt.mode_cmd       = cmd;
    result_nxt.traj_action    = traj;
    result_nxt.alarm          = alarm;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // Sequencer state, updated once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OFF;
      wait_r     <= '0;
      retry_r    <= 1'b0;
      last_req_r <= 1'b0;
    end else if (proc) begin
      phase_r    <= phase_nxt;
      wait_r     <= wait_nxt;
      retry_r    <= retry_nxt;
      last_req_r <= last_req_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= result_nxt;
    end
  end

  // A pending word must back up while the result register is held.
  `DASS_ASSERT_NOW(a_hold_backs_up, in_valid_r && out_valid_r && out_stall, in_stall,
    "input not stalled while result word is held")

  // A processed word always lands in the result register.
  `DASS_ASSERT_NEXT(a_proc_lands, proc, out_valid_r,
    "processed word missing from result register")

  // A forced stop by timeout always leaves the axis in the timed stop.
  `DASS_ASSERT_NOW(a_timeout_stops, out_valid_r && out_data_r.alarm == ALM_TIMEOUT,
    out_data_r.axis_state == PH_STOP2, "timeout alarm without timed stop")

  // No mode command means a zero command nibble.
  `DASS_ASSERT_NOW(a_idle_cmd_zero, out_valid_r && !out_data_r.mode_cmd_valid,
    out_data_r.mode_cmd == 4'd0, "mode command nibble set without valid")

endmodule

`default_nettype wire
